/* sv/epcfc_pkg.sv */
`timescale 1ns / 1ps
package epcfc_pkg;

   localparam logic [7:0] START_BYTE_RESET = 8'd187;
   localparam logic [7:0] END_BYTE_RESET   = 8'd126;
   localparam logic [7:0] MIN_LENGTH_RESET = 8'd13;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

   // Byte positions inside a frame.
   localparam logic [9:0] PC_HI_POS    = 10'd6;
   localparam logic [9:0] PC_LO_POS    = 10'd7;
   localparam logic [9:0] EPC_POS      = 10'd8;
   localparam logic [9:0] CRC_HI_POS   = 10'd8;
   localparam logic [9:0] CRC_LO_POS   = 10'd9;
   localparam logic [9:0] HEADER_BYTES = 10'd12;
   localparam logic [9:0] SHORTEST     = 10'd3;

   typedef enum logic [1:0] {
      CSR_START_BYTE       = 2'd0,
      CSR_END_BYTE         = 2'd1,
      CSR_MIN_FRAME_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_NEW_TAG      = 3'd0,
      ST_DUPLICATE    = 3'd1,
      ST_FRAMING_BAD  = 3'd2,
      ST_CHECKSUM_BAD = 3'd3,
      ST_EPC_TOO_LONG = 3'd4,
      ST_CRC_BAD      = 3'd5,
      ST_TABLE_FULL   = 3'd6
   } status_type;

   typedef struct packed {
      logic       byte_we;
      logic       clear_tags;
      logic       set_status;
      status_type status;
      logic       tag_init;
      logic       tag_next;
      logic       k_inc;
      logic       copy_we;
      logic       tag_commit;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_bad;
      logic sum_bad;
      logic elen_bad;
      logic crc_bad;
      logic tag_end;
      logic table_full;
      logic len_match;
      logic k_done;
      logic byte_eq;
      logic out_free;
   } dp_stat_type;

   // One byte of CRC-16/GENIBUS, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
      logic [15:0] c;
      c = crc_in ^ {d, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* sv/epcfc_ram.sv */
`timescale 1ns / 1ps
module epcfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/epcfc_ctrl.sv */
`timescale 1ns / 1ps
module epcfc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic                req_frame_last,
   input  epcfc_pkg::dp_stat_type stat,
   output epcfc_pkg::dp_cmd_type  cmd
);
   import epcfc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_TAG_START, S_TAG_READ, S_TAG_CMP, S_COPY_READ, S_COPY_WRITE, S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_CLEAR) begin
                  cmd.clear_tags = 1'b1;
               end else begin
                  cmd.byte_we = 1'b1;
                  if (req_frame_last) begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_CHECK: begin
            cmd.set_status = 1'b1;
            state_in       = S_RESULT;
            priority if (stat.frame_bad) begin
               cmd.status = ST_FRAMING_BAD;
            end else if (stat.sum_bad) begin
               cmd.status = ST_CHECKSUM_BAD;
            end else if (stat.elen_bad) begin
               cmd.status = ST_EPC_TOO_LONG;
            end else if (stat.crc_bad) begin
               cmd.status = ST_CRC_BAD;
            end else begin
               cmd.set_status = 1'b0;
               cmd.tag_init   = 1'b1;
               state_in       = S_TAG_START;
            end
         end
         S_TAG_START: begin
            priority if (stat.tag_end) begin
               if (stat.table_full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_TABLE_FULL;
                  state_in       = S_RESULT;
               end else begin
                  state_in = S_COPY_READ;
               end
            end else if (!stat.len_match) begin
               cmd.tag_next = 1'b1;
            end else begin
               state_in = S_TAG_READ;
            end
         end
         S_TAG_READ: begin
            if (stat.k_done) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_DUPLICATE;
               state_in       = S_RESULT;
            end else begin
               state_in = S_TAG_CMP;
            end
         end
         S_TAG_CMP: begin
            if (stat.byte_eq) begin
               cmd.k_inc = 1'b1;
               state_in  = S_TAG_READ;
            end else begin
               cmd.tag_next = 1'b1;
               state_in     = S_TAG_START;
            end
         end
         S_COPY_READ: begin
            if (stat.k_done) begin
               cmd.tag_commit = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_NEW_TAG;
               state_in       = S_RESULT;
            end else begin
               state_in = S_COPY_WRITE;
            end
         end
         S_COPY_WRITE: begin
            cmd.copy_we = 1'b1;
            cmd.k_inc   = 1'b1;
            state_in    = S_COPY_READ;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/epcfc_datapath.sv */
`timescale 1ns / 1ps
module epcfc_datapath #(
   parameter int FRAME_BYTES    = 128,
   parameter int MAX_TAGS       = 16,
   parameter int EPC_SLOT_BYTES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_write_data,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [15:0]            rsp_protocol_control,
   output logic [15:0]            rsp_epc_crc,
   output logic [5:0]             rsp_epc_length,
   output logic [3:0]             rsp_tag_slot,
   output logic [4:0]             rsp_tag_total,
   input  epcfc_pkg::dp_cmd_type  cmd,
   output epcfc_pkg::dp_stat_type stat
);
   import epcfc_pkg::*;

   localparam int CW    = $clog2(FRAME_BYTES + 1);
   localparam int FAW   = $clog2(FRAME_BYTES);
   localparam int TCW   = $clog2(MAX_TAGS + 1);
   localparam int TIW   = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int TDEP  = MAX_TAGS * EPC_SLOT_BYTES;
   localparam int TAW   = $clog2(TDEP);
   localparam int BW    = $clog2(TDEP + 1);

   logic [7:0]  start_ff, end_ff, min_len_ff;
   logic [CW-1:0] byte_count_ff;
   logic        overflow_ff;
   logic [7:0]  first_ff, last_ff, prev_ff, sum_ff, pc_hi_ff, pc_lo_ff;
   logic [7:0]  crc_rx_hi_ff, crc_rx_lo_ff;
   logic [15:0] crc_ff;
   logic [TCW-1:0] stored_ff, t_ff;
   logic [BW-1:0]  base_ff;
   logic [5:0]  k_ff;
   logic [5:0]  tag_len_ff [MAX_TAGS];
   status_type  res_status_ff;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [15:0] rsp_pc_ff, rsp_crc_ff;
   logic [5:0]  rsp_elen_ff;
   logic [3:0]  rsp_slot_ff;
   logic [4:0]  rsp_count_ff;

   logic [9:0]  len;
   logic [5:0]  elen;
   logic [5:0]  elen_byte;
   logic [9:0]  elen_w;
   logic        store_ok;
   logic [8:0]  frame_raddr;
   logic [15:0] tag_addr;
   logic [7:0]  frame_rdata, tag_rdata;
   logic [31:0] t_wide, stored_wide;

   assign len       = 10'(byte_count_ff);
   assign elen      = {pc_hi_ff[7:3], 1'b0};
   // The EPC length is already known while byte 6 itself is arriving.
   assign elen_byte = (len == PC_HI_POS) ? {req_data_byte[7:3], 1'b0} : elen;
   assign elen_w    = 10'(elen_byte);
   assign store_ok  = len < 10'(FRAME_BYTES);
   assign frame_raddr = 9'(k_ff) + 9'(EPC_POS);
   assign tag_addr  = 16'(base_ff) + 16'(k_ff);
   assign t_wide    = 32'(t_ff);
   assign stored_wide = 32'(stored_ff);

   epcfc_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock (clock),
      .we    (cmd.byte_we && store_ok),
      .waddr (byte_count_ff[FAW-1:0]),
      .wdata (req_data_byte),
      .raddr (frame_raddr[FAW-1:0]),
      .rdata (frame_rdata)
   );

   epcfc_ram #(.WIDTH(8), .DEPTH(TDEP)) u_tag_ram (
      .clock (clock),
      .we    (cmd.copy_we),
      .waddr (tag_addr[TAW-1:0]),
      .wdata (frame_rdata),
      .raddr (tag_addr[TAW-1:0]),
      .rdata (tag_rdata)
   );

   always_comb begin
      stat.frame_bad  = overflow_ff || len < SHORTEST || len < 10'(min_len_ff)
                        || first_ff != start_ff || last_ff != end_ff;
      stat.sum_bad    = (sum_ff - last_ff - prev_ff) != prev_ff;
      stat.elen_bad   = len < HEADER_BYTES + 10'(elen) || 10'(elen) > 10'(EPC_SLOT_BYTES);
      stat.crc_bad    = (crc_ff ^ CRC_XOROUT) != {crc_rx_hi_ff, crc_rx_lo_ff};
      stat.tag_end    = t_ff == stored_ff;
      stat.table_full = stored_ff >= TCW'(MAX_TAGS);
      stat.len_match  = tag_len_ff[t_ff[TIW-1:0]] == elen;
      stat.k_done     = k_ff == elen;
      stat.byte_eq    = tag_rdata == frame_rdata;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= START_BYTE_RESET;
         end_ff     <= END_BYTE_RESET;
         min_len_ff <= MIN_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_BYTE:       start_ff   <= csr_write_data;
            CSR_END_BYTE:         end_ff     <= csr_write_data;
            CSR_MIN_FRAME_LENGTH: min_len_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Running frame state: checksum, CRC and the fixed-position fields are
   // gathered as the bytes arrive, so frame end needs no second pass.
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         byte_count_ff <= '0;
         overflow_ff   <= 1'b0;
         sum_ff        <= '0;
         crc_ff        <= CRC_INIT;
         pc_hi_ff      <= '0;
         pc_lo_ff      <= '0;
         crc_rx_hi_ff  <= '0;
         crc_rx_lo_ff  <= '0;
      end else if (cmd.byte_we) begin
         if (store_ok) begin
            byte_count_ff <= byte_count_ff + CW'(1);
            if (len != 10'd0) begin
               sum_ff <= sum_ff + req_data_byte;
            end
            if (len == PC_HI_POS) begin
               pc_hi_ff <= req_data_byte;
            end
            if (len == PC_LO_POS) begin
               pc_lo_ff <= req_data_byte;
            end
            if (len >= PC_HI_POS && len <= PC_LO_POS + elen_w) begin
               crc_ff <= crc_byte(crc_ff, req_data_byte);
            end
            if (len == CRC_HI_POS + elen_w) begin
               crc_rx_hi_ff <= req_data_byte;
            end
            if (len == CRC_LO_POS + elen_w) begin
               crc_rx_lo_ff <= req_data_byte;
            end
         end else begin
            overflow_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_we && store_ok) begin
         if (len == 10'd0) begin
            first_ff <= req_data_byte;
         end
         prev_ff <= last_ff;
         last_ff <= req_data_byte;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.tag_commit) begin
         tag_len_ff[stored_ff[TIW-1:0]] <= elen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         t_ff      <= '0;
         base_ff   <= '0;
         k_ff      <= '0;
      end else begin
         if (cmd.clear_tags) begin
            stored_ff <= '0;
         end else if (cmd.tag_commit) begin
            stored_ff <= stored_ff + TCW'(1);
         end
         if (cmd.tag_init) begin
            t_ff    <= '0;
            base_ff <= '0;
            k_ff    <= '0;
         end else if (cmd.tag_next) begin
            t_ff    <= t_ff + TCW'(1);
            base_ff <= base_ff + BW'(EPC_SLOT_BYTES);
            k_ff    <= '0;
         end else if (cmd.k_inc) begin
            k_ff <= k_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= stored_wide[4:0];
         rsp_pc_ff     <= '0;
         rsp_crc_ff    <= '0;
         rsp_elen_ff   <= '0;
         rsp_slot_ff   <= '0;
         unique case (res_status_ff)
            ST_NEW_TAG, ST_DUPLICATE: begin
               rsp_pc_ff   <= {pc_hi_ff, pc_lo_ff};
               rsp_crc_ff  <= {crc_rx_hi_ff, crc_rx_lo_ff};
               rsp_elen_ff <= elen;
               rsp_slot_ff <= t_wide[3:0];
            end
            ST_CRC_BAD, ST_TABLE_FULL: begin
               rsp_pc_ff   <= {pc_hi_ff, pc_lo_ff};
               rsp_crc_ff  <= {crc_rx_hi_ff, crc_rx_lo_ff};
               rsp_elen_ff <= elen;
            end
            ST_EPC_TOO_LONG: begin
               rsp_pc_ff   <= {pc_hi_ff, pc_lo_ff};
               rsp_elen_ff <= elen;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_protocol_control = rsp_pc_ff;
   assign rsp_epc_crc          = rsp_crc_ff;
   assign rsp_epc_length       = rsp_elen_ff;
   assign rsp_tag_slot         = rsp_slot_ff;
   assign rsp_tag_total        = rsp_count_ff;

endmodule

/* sv/epc_inventory_frame_checker_top.sv */
// A request byte that does not close a frame is taken and gives no result. A closing byte
// is checked first; a frame that fails a check gets its status and is reported once the
// response output is free. Otherwise each stored tag of matching length is compared byte
// by byte; a new tag is copied byte by byte into the table. Throughput: one byte per cycle
// between frame ends. Reset is synchronous: it restores the register defaults and empties
// the tag table and the frame buffer at once; the stored bytes themselves are not cleared.
`timescale 1ns / 1ps
module epc_inventory_frame_checker_top #(
   parameter int FRAME_BYTES    = 128,
   parameter int MAX_TAGS       = 16,
   parameter int EPC_SLOT_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_protocol_control,
   output logic [15:0] rsp_epc_crc,
   output logic [5:0]  rsp_epc_length,
   output logic [3:0]  rsp_tag_slot,
   output logic [4:0]  rsp_tag_total
);
   import epcfc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   epcfc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_frame_last (req_frame_last),
      .stat           (stat),
      .cmd            (cmd)
   );

   epcfc_datapath #(
      .FRAME_BYTES    (FRAME_BYTES),
      .MAX_TAGS       (MAX_TAGS),
      .EPC_SLOT_BYTES (EPC_SLOT_BYTES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_protocol_control (rsp_protocol_control),
      .rsp_epc_crc          (rsp_epc_crc),
      .rsp_epc_length       (rsp_epc_length),
      .rsp_tag_slot         (rsp_tag_slot),
      .rsp_tag_total        (rsp_tag_total),
      .cmd                  (cmd),
      .stat                 (stat)
   );

endmodule

/* sv/epcfc_checker.sv */
`timescale 1ns / 1ps
module epcfc_checker #(
   parameter int MAX_TAGS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_protocol_control,
   input logic [15:0] rsp_epc_crc,
   input logic [5:0]  rsp_epc_length,
   input logic [3:0]  rsp_tag_slot,
   input logic [4:0]  rsp_tag_total
);
   import epcfc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tag_total))
      else $error("response changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_TABLE_FULL)
      else $error("undefined status code");

   a_early_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FRAMING_BAD || rsp_status == ST_CHECKSUM_BAD) |->
      rsp_protocol_control == 16'd0 && rsp_epc_crc == 16'd0 && rsp_epc_length == 6'd0
      && rsp_tag_slot == 4'd0)
      else $error("fields not cleared for a framing or checksum failure");

   a_too_long_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EPC_TOO_LONG |-> rsp_epc_crc == 16'd0 && rsp_tag_slot == 4'd0)
      else $error("crc or slot reported for an oversized EPC");

   a_new_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NEW_TAG && MAX_TAGS <= 16 |->
      5'(rsp_tag_slot) + 5'd1 == rsp_tag_total)
      else $error("new tag slot does not match tag total");

endmodule

bind epc_inventory_frame_checker_top epcfc_checker #(.MAX_TAGS(MAX_TAGS)) u_checker (.*);
